// File: rtl/lcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants for the lane-split limit counter with reserve.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int LANES     = 4;
  localparam int LANE_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int LANE_W    = 2;
  localparam int DIV_W     = 3;
  localparam int BITCNT_W  = $clog2(WORD_W);

  typedef logic [LANE_W-1:0]    lane_idx_t;
  typedef logic [LANE_BITS-1:0] lane_word_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [DIV_W-1:0]     div_t;

  // Register indexes of the configuration port
  localparam logic REG_COUNT_LIMIT  = 1'b0;
  localparam logic REG_ACTIVE_LANES = 1'b1;

  // Input actions
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam word_t LIMIT_RESET = word_t'(64'h8000_0000);
  localparam div_t  LANES_RESET = div_t'(4);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_SUM,
    ST_ADD_CHECK,
    ST_FOLD_GC,
    ST_FOLD_GR,
    ST_HR_USED,
    ST_HR_SUB,
    ST_HR_CMP,
    ST_ADD_GC,
    ST_DIV,
    ST_CLAMP,
    ST_GR_ADD,
    ST_GC_SUB,
    ST_OUT
  } state_t;

endpackage

// File: rtl/limit_counter_lane_reserve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_counter_lane_reserve
// Limited counter split into lane counters plus a global count and reserve,
// run by a small sequencer around one shared 34-bit add/subtract unit.
// ----------------------------------------------------------------------------
// A read steps through ST_RD_SUM once per lane and then presents its total;
// an add on the fast path goes from ST_ADD_CHECK straight to the result; the
// slow path is set mostly by the 32-step restoring division of the headroom
// through the shared adder. Throughput: one beat at a time; the next beat is
// taken the cycle after the result beat leaves. Synchronous reset clears all
// counts, maxima, the global count and reserve, and loads count_limit = 2^31,
// active_lanes = 4.
module limit_counter_lane_reserve (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic                  wr_index,
  input  lcr_pkg::word_t        wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  lcr_pkg::lane_idx_t    lane,
  input  lcr_pkg::word_t        delta,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  ok,
  output lcr_pkg::word_t        total
);
  import lcr_pkg::*;

  state_t     state, state_next;

  word_t      count_limit;
  div_t       active_lanes;
  lane_word_t lane_count [LANES];
  lane_word_t lane_max   [LANES];
  word_t      global_count;
  word_t      global_reserve;

  lane_idx_t  idx;
  lane_idx_t  ln;
  word_t      delta_r;
  logic       fold_all;
  logic       flushed;
  logic       refill;
  logic [WORD_W:0] used;
  word_t      hr;
  div_t       rem;
  logic [BITCNT_W-1:0] bitcnt;
  lane_word_t cm;
  word_t      acc;

  // Shared arithmetic unit
  logic [WORD_W+1:0] alu_a, alu_b, alu_res;
  logic              alu_sub;
  logic              alu_neg;
  word_t             alu_sat;

  lane_idx_t  fold_sel;
  div_t       divisor;
  logic       fast;
  lane_word_t half_cm;

  assign alu_res  = alu_sub ? alu_a - alu_b : alu_a + alu_b;
  assign alu_neg  = alu_res[WORD_W+1];
  assign alu_sat  = (alu_res[WORD_W+1:WORD_W] != 2'b00) ? '1 : alu_res[WORD_W-1:0];
  assign fold_sel = fold_all ? idx : ln;
  assign divisor  = (active_lanes == '0) ? div_t'(1) : active_lanes;
  assign half_cm  = cm >> 1;
  assign fast     = (delta_r[WORD_W-1:LANE_BITS] == '0) &&
                    (alu_res[LANE_BITS:0] <= {1'b0, lane_max[ln]});

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (action == ACT_READ) ? ST_RD_SUM : ST_ADD_CHECK;
        end
      end
      ST_RD_SUM: begin
        alu_a = {2'b00, acc};
        alu_b = {{(WORD_W+2-LANE_BITS){1'b0}}, lane_count[idx]};
        if (idx == lane_idx_t'(LANES - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_ADD_CHECK: begin
        alu_a = {{(WORD_W+2-LANE_BITS){1'b0}}, lane_count[ln]};
        alu_b = {{(WORD_W+2-LANE_BITS){1'b0}}, delta_r[LANE_BITS-1:0]};
        state_next = fast ? ST_OUT : ST_FOLD_GC;
      end
      ST_FOLD_GC: begin
        alu_a = {2'b00, global_count};
        alu_b = {{(WORD_W+2-LANE_BITS){1'b0}}, lane_count[fold_sel]};
        state_next = ST_FOLD_GR;
      end
      ST_FOLD_GR: begin
        alu_a   = {2'b00, global_reserve};
        alu_b   = {{(WORD_W+2-LANE_BITS){1'b0}}, lane_max[fold_sel]};
        alu_sub = 1'b1;
        if (fold_all && idx != lane_idx_t'(LANES - 1)) begin
          state_next = ST_FOLD_GC;
        end else begin
          state_next = ST_HR_USED;
        end
      end
      ST_HR_USED: begin
        alu_a = {2'b00, global_count};
        alu_b = {2'b00, global_reserve};
        state_next = ST_HR_SUB;
      end
      ST_HR_SUB: begin
        alu_a   = {2'b00, count_limit};
        alu_b   = {1'b0, used};
        alu_sub = 1'b1;
        state_next = refill ? ST_DIV : ST_HR_CMP;
      end
      ST_HR_CMP: begin
        alu_a   = {2'b00, hr};
        alu_b   = {2'b00, delta_r};
        alu_sub = 1'b1;
        if (!alu_neg) begin
          state_next = ST_ADD_GC;
        end else if (!flushed && global_reserve != '0) begin
          state_next = ST_FOLD_GC;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_ADD_GC: begin
        alu_a = {2'b00, global_count};
        alu_b = {2'b00, delta_r};
        state_next = ST_HR_USED;
      end
      ST_DIV: begin
        alu_a   = {{(WORD_W+1-DIV_W){1'b0}}, rem, hr[WORD_W-1]};
        alu_b   = {{(WORD_W+2-DIV_W){1'b0}}, divisor};
        alu_sub = 1'b1;
        if (bitcnt == BITCNT_W'(WORD_W - 1)) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        state_next = ST_GR_ADD;
      end
      ST_GR_ADD: begin
        alu_a = {2'b00, global_reserve};
        alu_b = {{(WORD_W+2-LANE_BITS){1'b0}}, cm};
        state_next = ST_GC_SUB;
      end
      ST_GC_SUB: begin
        alu_a   = {2'b00, global_count};
        alu_b   = {{(WORD_W+2-LANE_BITS){1'b0}}, half_cm};
        alu_sub = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit    <= LIMIT_RESET;
      active_lanes   <= LANES_RESET;
      global_count   <= '0;
      global_reserve <= '0;
      for (int i = 0; i < LANES; i++) begin
        lane_count[i] <= '0;
        lane_max[i]   <= '0;
      end
      idx      <= '0;
      fold_all <= 1'b0;
      flushed  <= 1'b0;
      refill   <= 1'b0;
      rem      <= '0;
      bitcnt   <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_COUNT_LIMIT:  count_limit  <= wr_data;
          REG_ACTIVE_LANES: active_lanes <= wr_data[DIV_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ln       <= lane;
            delta_r  <= delta;
            acc      <= global_count;
            idx      <= '0;
            fold_all <= 1'b0;
            flushed  <= 1'b0;
            refill   <= 1'b0;
          end
        end
        ST_RD_SUM: begin
          acc <= alu_sat;
          idx <= idx + lane_idx_t'(1);
          if (idx == lane_idx_t'(LANES - 1)) begin
            ok    <= 1'b1;
            total <= alu_sat;
          end
        end
        ST_ADD_CHECK: begin
          total <= '0;
          if (fast) begin
            lane_count[ln] <= alu_res[LANE_BITS-1:0];
            ok             <= 1'b1;
          end
        end
        ST_FOLD_GC: begin
          global_count <= alu_sat;
        end
        ST_FOLD_GR: begin
          global_reserve       <= alu_neg ? '0 : alu_res[WORD_W-1:0];
          lane_count[fold_sel] <= '0;
          lane_max[fold_sel]   <= '0;
          if (fold_all) begin
            if (idx == lane_idx_t'(LANES - 1)) begin
              fold_all <= 1'b0;
              flushed  <= 1'b1;
            end else begin
              idx <= idx + lane_idx_t'(1);
            end
          end
        end
        ST_HR_USED: begin
          used <= alu_res[WORD_W:0];
        end
        ST_HR_SUB: begin
          // Headroom is zero when the count and reserve already reach the limit.
          hr     <= alu_neg ? '0 : alu_res[WORD_W-1:0];
          rem    <= '0;
          bitcnt <= '0;
        end
        ST_HR_CMP: begin
          if (alu_neg) begin
            if (!flushed && global_reserve != '0) begin
              fold_all <= 1'b1;
              idx      <= '0;
            end else begin
              ok <= 1'b0;
            end
          end
        end
        ST_ADD_GC: begin
          global_count <= alu_sat;
          refill       <= 1'b1;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle shifted into hr.
          if (!alu_neg) begin
            rem <= alu_res[DIV_W-1:0];
            hr  <= {hr[WORD_W-2:0], 1'b1};
          end else begin
            rem <= {rem[DIV_W-2:0], hr[WORD_W-1]};
            hr  <= {hr[WORD_W-2:0], 1'b0};
          end
          bitcnt <= bitcnt + BITCNT_W'(1);
        end
        ST_CLAMP: begin
          cm <= (hr[WORD_W-1:LANE_BITS] != '0) ? '1 : hr[LANE_BITS-1:0];
        end
        ST_GR_ADD: begin
          global_reserve <= alu_sat;
        end
        ST_GC_SUB: begin
          // The lane gets half its maximum, but never more than the global count.
          if (alu_neg) begin
            lane_count[ln] <= global_count[LANE_BITS-1:0];
            global_count   <= '0;
          end else begin
            lane_count[ln] <= half_cm;
            global_count   <= alu_res[WORD_W-1:0];
          end
          lane_max[ln] <= cm;
          ok           <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: tb/lcr_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_count_checker
// Watches the register port and both channels of the lane-split limit
// counter, keeps its own copy of the counter state, predicts the reply to
// every accepted beat and compares each reply beat against the oldest one.
// ----------------------------------------------------------------------------
module lcr_count_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  lcr_pkg::word_t     wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  lcr_pkg::lane_idx_t lane,
  input  lcr_pkg::word_t     delta,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               ok,
  input  lcr_pkg::word_t     total,
  output int                 beats_in,
  output int                 beats_out,
  output int                 mismatches,
  output int                 reads_seen,
  output int                 adds_taken,
  output int                 adds_refused
);

  import lcr_pkg::*;

  localparam logic [63:0] LANE_CAP_FULL = (64'd1 << LANE_BITS) - 64'd1;
  localparam logic [63:0] WORD_CAP      = 64'hFFFF_FFFF;

  typedef struct packed {
    logic  ok;
    word_t total;
  } reply_t;

  reply_t     reply_q[$];
  reply_t     want;
  reply_t     got_want;
  int         bad;

  // Shadow copy of the counter state and its two registers
  word_t      limit_reg;
  div_t       lanes_reg;
  lane_word_t lane_cnt [LANES];
  lane_word_t lane_cap [LANES];
  word_t      glob_cnt;
  word_t      glob_rsv;

  function automatic word_t sat32(logic [63:0] v);
    return (v > WORD_CAP) ? '1 : v[31:0];
  endfunction

  function automatic word_t room();
    logic [63:0] used;
    used = 64'(glob_cnt) + 64'(glob_rsv);
    return (used >= 64'(limit_reg)) ? '0 : word_t'(64'(limit_reg) - used);
  endfunction

  function automatic void fold_lane(int i);
    glob_cnt = sat32(64'(glob_cnt) + 64'(lane_cnt[i]));
    glob_rsv = (glob_rsv >= 32'(lane_cap[i])) ? glob_rsv - 32'(lane_cap[i]) : '0;
    lane_cnt[i] = '0;
    lane_cap[i] = '0;
  endfunction

  function automatic void refill_lane(int i);
    logic [63:0] div;
    logic [63:0] cap;
    logic [63:0] take;
    // A lane count of zero in the register divides as one.
    div = (lanes_reg == '0) ? 64'd1 : 64'(lanes_reg);
    cap = 64'(room()) / div;
    if (cap > LANE_CAP_FULL) cap = LANE_CAP_FULL;
    glob_rsv = sat32(64'(glob_rsv) + cap);
    take = cap / 2;
    if (take > 64'(glob_cnt)) take = 64'(glob_cnt);
    glob_cnt    = glob_cnt - word_t'(take);
    lane_cnt[i] = lane_word_t'(take);
    lane_cap[i] = lane_word_t'(cap);
  endfunction

  function automatic logic add_on_lane(int i, word_t d);
    int k;
    if (i >= LANES) return 1'b0;
    if (64'(d) <= LANE_CAP_FULL && 64'(lane_cnt[i]) + 64'(d) <= 64'(lane_cap[i])) begin
      lane_cnt[i] = lane_cnt[i] + lane_word_t'(d);
      return 1'b1;
    end
    fold_lane(i);
    if (room() < d) begin
      // Flushing only happens when some lane still holds reserve.
      if (glob_rsv != '0) begin
        for (k = 0; k < LANES; k++) fold_lane(k);
      end
      if (room() < d) return 1'b0;
    end
    glob_cnt = sat32(64'(glob_cnt) + 64'(d));
    refill_lane(i);
    return 1'b1;
  endfunction

  function automatic word_t count_sum();
    logic [63:0] s;
    int          k;
    s = 64'(glob_cnt);
    for (k = 0; k < LANES; k++) s = 64'(sat32(s + 64'(lane_cnt[k])));
    return s[31:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      limit_reg = LIMIT_RESET;
      lanes_reg = LANES_RESET;
      for (int k = 0; k < LANES; k++) begin
        lane_cnt[k] = '0;
        lane_cap[k] = '0;
      end
      glob_cnt = '0;
      glob_rsv = '0;
      reply_q.delete();
      beats_in     <= 0;
      beats_out    <= 0;
      mismatches   <= 0;
      reads_seen   <= 0;
      adds_taken   <= 0;
      adds_refused <= 0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_COUNT_LIMIT) limit_reg = wr_data;
        else lanes_reg = div_t'(wr_data);
      end

      if (in_valid && in_ready) begin
        beats_in <= beats_in + 1;
        if (action == ACT_READ) begin
          want.ok    = 1'b1;
          want.total = count_sum();
          reads_seen <= reads_seen + 1;
        end else begin
          want.ok    = add_on_lane(int'(lane), delta);
          want.total = '0;
          if (want.ok) adds_taken <= adds_taken + 1;
          else adds_refused <= adds_refused + 1;
        end
        reply_q.push_back(want);
      end

      if (out_valid && out_ready) begin
        beats_out <= beats_out + 1;
        bad = 0;
        if (reply_q.size() == 0) begin
          $error("reply beat with nothing predicted: ok=%0d total=%0h", ok, total);
          bad = 1;
        end else begin
          got_want = reply_q.pop_front();
          if (ok !== got_want.ok) begin
            $error("field ok: expected %0d, actual %0d", got_want.ok, ok);
            bad++;
          end
          if (total !== got_want.total) begin
            $error("field total: expected %0h, actual %0h", got_want.total, total);
            bad++;
          end
        end
        mismatches <= mismatches + bad;
      end
    end
  end

endmodule

// File: tb/limit_counter_lane_reserve_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_counter_lane_reserve_tb
// Drives adds and reads into the lane-split limit counter over a series of
// limit and lane-count settings with random source gaps and sink stalls; the
// checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module limit_counter_lane_reserve_tb;

  import lcr_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;

  logic      clk;
  logic      rst       = 1'b1;
  logic      wr_en     = 1'b0;
  logic      wr_index  = REG_COUNT_LIMIT;
  word_t     wr_data   = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  logic      action    = ACT_ADD;
  lane_idx_t lane      = '0;
  word_t     delta     = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  logic      ok;
  word_t     total;

  int beats_in;
  int beats_out;
  int mismatches;
  int reads_seen;
  int adds_taken;
  int adds_refused;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cycles         = 0;
  int settings_used  = 0;

  limit_counter_lane_reserve i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .lane     (lane),
    .delta    (delta),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ok       (ok),
    .total    (total)
  );

  lcr_count_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .lane        (lane),
    .delta       (delta),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .total       (total),
    .beats_in    (beats_in),
    .beats_out   (beats_out),
    .mismatches  (mismatches),
    .reads_seen  (reads_seen),
    .adds_taken  (adds_taken),
    .adds_refused(adds_refused)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Valid is left high after acceptance so back-to-back beats need no toggle.
  task automatic send_beat(logic act, lane_idx_t ln, word_t d);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    lane     <= ln;
    delta    <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // The beat counters are registered, so drain waits for them to update before comparing them.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_out != beats_in) @(posedge clk);
  endtask

  task automatic configure(word_t limit_val, div_t lanes_val);
    drain();
    wr_en    <= 1'b1;
    wr_index <= REG_COUNT_LIMIT;
    wr_data  <= limit_val;
    @(posedge clk);
    wr_index <= REG_ACTIVE_LANES;
    wr_data  <= word_t'(lanes_val);
    @(posedge clk);
    wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic random_beat();
    int        pick;
    word_t     d;
    lane_idx_t ln;
    ln   = lane_idx_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 22) begin
      send_beat(ACT_READ, ln, $urandom);
    end else begin
      // Mostly small deltas that stay on the fast path, with a tail of large
      // ones that force folding, flushing and refusals.
      pick = $urandom_range(99);
      if (pick < 40) d = $urandom_range(16);
      else if (pick < 60) d = $urandom_range(1023);
      else if (pick < 75) d = $urandom_range(65536, 60000);
      else if (pick < 85) d = $urandom_range(1 << 20);
      else if (pick < 95) d = $urandom >> $urandom_range(31);
      else d = $urandom;
      send_beat(ACT_ADD, ln, d);
    end
  endtask

  task automatic run_phase(word_t limit_val, div_t lanes_val, int src_pct, int sink_pct,
                           int n);
    configure(limit_val, lanes_val);
    src_idle_pct   = src_pct;
    sink_stall_pct <= sink_pct;
    repeat (n) random_beat();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a read of the empty counter, then a huge add while no
    // lane holds reserve, so no flush is made and the add fails.
    send_beat(ACT_READ, 2'd0, 32'h0);
    send_beat(ACT_ADD, 2'd3, 32'hFFFF_FFFF);
    send_beat(ACT_ADD, 2'd0, 32'h0);
    send_beat(ACT_ADD, 2'd0, 32'h1);
    send_beat(ACT_ADD, 2'd0, 32'h2);
    send_beat(ACT_ADD, 2'd1, 32'h0000_FFFF);
    send_beat(ACT_ADD, 2'd2, 32'h0001_0000);
    send_beat(ACT_ADD, 2'd3, 32'h8000_0000);
    send_beat(ACT_READ, 2'd3, 32'hFFFF_FFFF);
    send_beat(ACT_ADD, 2'd1, 32'h7FFF_0000);
    send_beat(ACT_READ, 2'd1, 32'h5555_5555);

    // A limit below what is already counted leaves no headroom at all.
    configure(32'd100, div_t'(3));
    send_beat(ACT_ADD, 2'd2, 32'd5);
    send_beat(ACT_ADD, 2'd0, 32'd200);
    send_beat(ACT_READ, 2'd0, 32'hAAAA_AAAA);

    // Zero lanes in the register divides the headroom as a single lane.
    configure(32'hFFFF_FFFF, div_t'(0));
    send_beat(ACT_ADD, 2'd1, 32'hF000_0000);
    send_beat(ACT_ADD, 2'd2, 32'h0FFF_FFFF);
    send_beat(ACT_READ, 2'd2, 32'h0);
    send_beat(ACT_ADD, 2'd3, 32'hFFFF_FFFF);
    send_beat(ACT_READ, 2'd3, 32'h0);

    configure(32'd1000, div_t'(7));
    send_beat(ACT_ADD, 2'd0, 32'd10);
    send_beat(ACT_ADD, 2'd1, 32'd999);
    send_beat(ACT_READ, 2'd1, 32'h0);

    run_phase(32'h8000_0000, div_t'(4), 0, 0, 92);
    run_phase(32'hFFFF_FFFF, div_t'(1), 62, 0, 92);
    run_phase(32'd300000, div_t'(7), 0, 62, 92);
    run_phase(32'd0, div_t'(0), 29, 29, 92);
    run_phase(32'd5000, div_t'(2), 0, 0, 92);
    run_phase($urandom, div_t'($urandom_range(7)), 29, 29, 92);
    run_phase(32'd70000, div_t'(5), 62, 0, 92);
    run_phase(32'hFFFF_FFFF, div_t'(4), 0, 62, 92);

    drain();
    sink_stall_pct <= 0;
    repeat (60) @(posedge clk);

    $display("Covered %0d beats over %0d register settings: %0d reads, %0d adds taken, %0d refused.",
             beats_in, settings_used, reads_seen, adds_taken, adds_refused);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
